>>> rtl/tvs_pkg.sv
`default_nettype none
package tvs_pkg;

   typedef enum logic [2:0] {
      ACT_PUSH  = 3'd0,
      ACT_POP   = 3'd1,
      ACT_PEEK  = 3'd2,
      ACT_DUP   = 3'd3,
      ACT_SWAP  = 3'd4,
      ACT_ROT   = 3'd5,
      ACT_DROP  = 3'd6,
      ACT_RESET = 3'd7
   } action_type;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_UNDER = 2'd1;
   localparam logic [1:0] ST_OVER  = 2'd2;

   localparam logic [2:0] KIND_ERROR  = 3'd0;
   localparam logic [2:0] KIND_NUMBER = 3'd1;
   localparam logic [2:0] KIND_STRING = 3'd2;
   localparam logic [2:0] KIND_BUFFER = 3'd4;

   // datapath commands issued by the controller
   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_WRITE_NEW,   // write push data at fill
      CMD_WRITE_DUP,   // write rd_a (old top) at fill
      CMD_SWAP,        // top <- rd_b (old second)
      CMD_SWAP_B,      // second <- rd_a (old top)
      CMD_ROT_A,       // top <- rd_b (old second), fetch third into rd_b
      CMD_ROT_B,       // second <- rd_b (old third)
      CMD_ROT_C        // third <- rd_a (old top)
   } cmd_type;

   typedef struct packed {
      logic       load;       // capture request payload
      cmd_type    cmd;
      logic       rd_issue;   // read the addresses for this step
      logic       rsp_load;   // capture result from top read
      logic       rsp_zero;   // result entry is zero
   } ctl_type;

endpackage
`default_nettype wire

>>> rtl/tvs_datapath.sv
`default_nettype none
module tvs_datapath
   import tvs_pkg::*;
#(
   parameter int STACK_DEPTH = 64,
   parameter int AW = 6,
   parameter int CW = 7
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire ctl_type       ctl,
   input  wire logic [CW-1:0] fill,
   input  wire logic [66:0]   push_entry,
   output logic [66:0]        rsp_entry
);

   // Two entries are read per step: a = top-side, b = one below.
   logic [66:0] mem [STACK_DEPTH];
   logic [66:0] rd_a;
   logic [66:0] rd_b;
   logic [66:0] push_ff;
   logic [66:0] rsp_ff;
   logic [66:0] rsp_in;
   logic [AW-1:0] top_a, sec_a, thd_a;

   assign top_a = AW'(fill - CW'(1));
   assign sec_a = AW'(fill - CW'(2));
   assign thd_a = AW'(fill - CW'(3));

   // hold pushed entry
   always_ff @(posedge clock) begin
      if (ctl.load) push_ff <= push_entry;
   end

   // read port pair: top/second, or keep old top and fetch third for rot
   always_ff @(posedge clock) begin
      if (ctl.rd_issue) begin
         if (ctl.cmd == CMD_ROT_A) begin
            rd_b <= mem[thd_a];
         end else begin
            rd_a <= mem[top_a];
            rd_b <= mem[sec_a];
         end
      end
   end

   // write port: one address per cycle
   always_ff @(posedge clock) begin
      unique case (ctl.cmd)
         CMD_WRITE_NEW:       mem[AW'(fill)] <= push_ff;
         CMD_WRITE_DUP:       mem[AW'(fill)] <= rd_a;
         CMD_SWAP, CMD_ROT_A: mem[top_a] <= rd_b;
         CMD_SWAP_B:          mem[sec_a] <= rd_a;
         CMD_ROT_B:           mem[sec_a] <= rd_b;
         CMD_ROT_C:           mem[thd_a] <= rd_a;
         CMD_NONE: ;
      endcase
   end

   always_comb begin
      rsp_in = rsp_ff;
      if (ctl.rsp_zero) rsp_in = '0;
      else if (ctl.rsp_load) rsp_in = rd_a;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_ff <= '0;
      else rsp_ff <= rsp_in;
   end

   assign rsp_entry = rsp_ff;

endmodule
`default_nettype wire

>>> rtl/tvs_ctrl.sv
`default_nettype none
module tvs_ctrl
   import tvs_pkg::*;
#(
   parameter int STACK_DEPTH = 64,
   parameter int CW = 7
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          in_valid,
   output logic               in_ready,
   input  wire logic [2:0]    in_action,
   output ctl_type            ctl,
   output logic [CW-1:0]      fill,
   output logic               out_valid,
   input  wire logic          out_ready,
   output logic [1:0]         out_status
);

   typedef enum logic [2:0] {
      S_IDLE, S_READ, S_EXEC, S_ROT2, S_RDTOP, S_SHOW, S_OUT
   } state_type;

   state_type     state_ff, state_in;
   action_type    act_ff, act_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic [1:0]    stat_ff, stat_in;

   assign fill = fill_ff;
   assign in_ready = (state_ff == S_IDLE);
   assign out_valid = (state_ff == S_OUT);
   assign out_status = stat_ff;

   // Sequence: READ captures fill checks, EXEC writes (pop goes to OUT), ROT2 ends swap/rot, RDTOP rereads top.
   always_comb begin
      state_in = state_ff;
      act_in = act_ff;
      fill_in = fill_ff;
      stat_in = stat_ff;
      ctl = '0;
      unique case (state_ff)
         S_IDLE: begin
            ctl.load = 1'b1;
            if (in_valid) begin
               act_in = action_type'(in_action);
               state_in = S_READ;
            end
         end
         S_READ: begin
            stat_in = ST_OK;
            ctl.rd_issue = 1'b1;
            state_in = S_EXEC;
            unique case (act_ff)
               ACT_PUSH: if (fill_ff >= CW'(STACK_DEPTH)) stat_in = ST_OVER;
               ACT_POP, ACT_PEEK, ACT_DROP:
                  if (fill_ff == '0) stat_in = ST_UNDER;
               ACT_DUP:
                  if (fill_ff == '0) stat_in = ST_UNDER;
                  else if (fill_ff >= CW'(STACK_DEPTH)) stat_in = ST_OVER;
               ACT_SWAP: if (fill_ff < CW'(2)) stat_in = ST_UNDER;
               ACT_ROT:  if (fill_ff < CW'(3)) stat_in = ST_UNDER;
               default: ;
            endcase
         end
         S_EXEC: begin
            state_in = S_RDTOP;
            if (stat_ff == ST_OK) begin
               unique case (act_ff)
                  ACT_PUSH: begin
                     ctl.cmd = CMD_WRITE_NEW;
                     fill_in = fill_ff + CW'(1);
                  end
                  ACT_DUP: begin
                     ctl.cmd = CMD_WRITE_DUP;
                     fill_in = fill_ff + CW'(1);
                  end
                  ACT_POP: begin
                     ctl.rsp_load = 1'b1;
                     fill_in = fill_ff - CW'(1);
                     state_in = S_OUT;
                  end
                  ACT_DROP: fill_in = fill_ff - CW'(1);
                  ACT_SWAP: begin
                     ctl.cmd = CMD_SWAP;
                     state_in = S_ROT2;
                  end
                  ACT_ROT: begin
                     ctl.cmd = CMD_ROT_A;
                     ctl.rd_issue = 1'b1;
                     state_in = S_ROT2;
                  end
                  ACT_RESET: fill_in = '0;
                  default: ;
               endcase
            end else if (act_ff == ACT_POP) begin
               ctl.rsp_zero = 1'b1;
               state_in = S_OUT;
            end
         end
         S_ROT2: begin
            state_in = S_RDTOP;
            if (act_ff == ACT_SWAP) begin
               // second <- old top, held in rd_a
               ctl.cmd = CMD_SWAP_B;
            end else begin
               // second <- old third, fetched into rd_b
               ctl.cmd = CMD_ROT_B;
            end
         end
         S_RDTOP: begin
            ctl.rd_issue = 1'b1;
            // finish rot: third <- old top, still held in rd_a
            if (act_ff == ACT_ROT && stat_ff == ST_OK) ctl.cmd = CMD_ROT_C;
            state_in = S_SHOW;
         end
         S_SHOW: begin
            if (fill_ff == '0) ctl.rsp_zero = 1'b1;
            else ctl.rsp_load = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: if (out_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fill_ff  <= '0;
         stat_ff  <= ST_OK;
         act_ff   <= ACT_PUSH;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         stat_ff  <= stat_in;
         act_ff   <= act_in;
      end
   end

endmodule
`default_nettype wire

>>> rtl/tagged_value_stack.sv
`default_nettype none
// Each action runs through the controller states READ, EXEC, RDTOP, SHOW
// and OUT; pop goes from EXEC straight to OUT, and swap and rot pass ROT2
// between EXEC and RDTOP unless they find too few entries. One item at a
// time, set by the single write port of the entry memory and the controller
// sequence: a new request is taken only after the last result is accepted.
// Reset: synchronous, active high; empties the stack, memory not cleared.
module tagged_value_stack
   import tvs_pkg::*;
#(
   parameter int STACK_DEPTH = 64
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [71:0]  req_tdata,  // action[2:0], push_kind[5:3], push_word[69:6]
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // top_kind[2:0], top_word[66:3], number_view[98:67],
   // reference_view[162:99], depth_now[169:163], status[171:170]
   output logic [175:0]      rsp_tdata
);

   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CW = $clog2(STACK_DEPTH + 1);

   ctl_type       ctl;
   logic [CW-1:0] fill;
   logic [66:0]   rsp_entry, push_entry;
   logic [1:0]    status;
   logic [2:0]    kind;
   logic [63:0]   word;

   assign push_entry = {req_tdata[69:6], req_tdata[5:3]};

   tvs_ctrl #(.STACK_DEPTH(STACK_DEPTH), .CW(CW)) u_ctrl (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready),
      .in_action(req_tdata[2:0]),
      .ctl(ctl), .fill(fill),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_status(status)
   );

   tvs_datapath #(.STACK_DEPTH(STACK_DEPTH), .AW(AW), .CW(CW)) u_dp (
      .clock(clock), .reset(reset), .ctl(ctl), .fill(fill),
      .push_entry(push_entry),
      .rsp_entry(rsp_entry)
   );

   assign kind = rsp_entry[2:0];
   assign word = rsp_entry[66:3];

   // views of the shown entry
   assign rsp_tdata[2:0]     = kind;
   assign rsp_tdata[66:3]    = word;
   assign rsp_tdata[98:67]   = (kind == KIND_NUMBER) ? word[31:0] : 32'd0;
   assign rsp_tdata[162:99]  = (kind >= KIND_STRING && kind <= KIND_BUFFER) ? word : 64'd0;
   assign rsp_tdata[169:163] = 7'(fill);
   assign rsp_tdata[171:170] = status;
   assign rsp_tdata[175:172] = '0;

`ifndef ASSERT_OFF
   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      fill <= CW'(STACK_DEPTH)) else $error("fill above depth");
   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid)) else $error("busy overlap");
   a_over_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && status == ST_OVER |-> fill == CW'(STACK_DEPTH))
      else $error("overflow without full");
`endif

endmodule
`default_nettype wire
